@@ hw/rtl/ewma_imu_variance_tracker_defines.svh @@
// Assertion macros for the checker file of the variance tracker.
`ifndef EWMA_IMU_VARIANCE_TRACKER_DEFINES_SVH
`define EWMA_IMU_VARIANCE_TRACKER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define EVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("variance tracker check failed");

// Next-cycle implication, held off while reset is asserted.
`define EVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("variance tracker check failed");

`endif

@@ hw/rtl/ewma_ivt_pkg.sv @@
package ewma_ivt_pkg;

    // Number of tracked axes: accel x, y, z then gyro x, y, z.
    localparam int AXES = 6;
    localparam int AXW  = $clog2(AXES);

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 48;
    localparam int ALPHA_W  = 17;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 52;

    localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd655;
    localparam logic [COUNT_W-1:0] WARM_RESET  = 16'd100;
    localparam logic [COUNT_W-1:0] WARM_MIN    = 16'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

    // Steps of the per-axis update sequence.
    typedef enum logic [3:0] {
        ST_MAG,   // magnitude of sample minus old mean
        ST_SQH,   // square, upper half of magnitude
        ST_SQL,   // square, lower half of magnitude
        ST_TAH,   // square times alpha, upper part
        ST_TAL,   // square times alpha, lower part
        ST_TBH,   // variance times beta, upper part
        ST_TBL,   // variance times beta, lower part, write variance
        ST_MA,    // sample times alpha
        ST_MB     // mean times beta, write mean
    } t_step;

    typedef struct packed {
        logic           accept;
        logic           run;
        t_step          step;
        logic [AXW-1:0] axis;
        logic           load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_run;
    } t_dp_sts;

endpackage

@@ hw/rtl/ewma_ivt_ctrl.sv @@
module ewma_ivt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  ewma_ivt_pkg::t_dp_sts  i_sts,
    output ewma_ivt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    ewma_ivt_pkg::t_step             r_step, n_step;
    logic [ewma_ivt_pkg::AXW-1:0]    r_axis, n_axis;
    logic                            r_out_valid, n_out_valid;
    logic                            accept;
    logic                            load_out;
    logic                            last_axis;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign last_axis = (r_axis == ewma_ivt_pkg::AXW'(ewma_ivt_pkg::AXES - 1));

    // Commands to the datapath.
    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.run      = (r_state == S_RUN);
        o_cmd.step     = r_step;
        o_cmd.axis     = r_axis;
        o_cmd.load_out = load_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, step and axis.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_out_valid = load_out || (r_out_valid && i_out_stall);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step  = ewma_ivt_pkg::ST_MAG;
                    n_axis  = '0;
                    n_state = i_sts.need_run ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                case (r_step)
                    ewma_ivt_pkg::ST_MAG: n_step = ewma_ivt_pkg::ST_SQH;
                    ewma_ivt_pkg::ST_SQH: n_step = ewma_ivt_pkg::ST_SQL;
                    ewma_ivt_pkg::ST_SQL: n_step = ewma_ivt_pkg::ST_TAH;
                    ewma_ivt_pkg::ST_TAH: n_step = ewma_ivt_pkg::ST_TAL;
                    ewma_ivt_pkg::ST_TAL: n_step = ewma_ivt_pkg::ST_TBH;
                    ewma_ivt_pkg::ST_TBH: n_step = ewma_ivt_pkg::ST_TBL;
                    ewma_ivt_pkg::ST_TBL: n_step = ewma_ivt_pkg::ST_MA;
                    ewma_ivt_pkg::ST_MA:  n_step = ewma_ivt_pkg::ST_MB;
                    ewma_ivt_pkg::ST_MB: begin
                        n_step = ewma_ivt_pkg::ST_MAG;
                        if (last_axis) begin
                            n_state = S_DONE;
                        end else begin
                            n_axis = r_axis + 1'b1;
                        end
                    end
                    default: n_step = ewma_ivt_pkg::ST_MAG;
                endcase
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ewma_ivt_pkg::ST_MAG;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/ewma_ivt_dp.sv @@
module ewma_ivt_dp (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [ewma_ivt_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [ewma_ivt_pkg::CFG_W-1:0]               i_cfg_data,
    input  logic                                         i_func,
    input  logic signed [ewma_ivt_pkg::SAMPLE_W-1:0]     i_x [ewma_ivt_pkg::AXES],
    input  logic                                         i_sample_valid,
    input  logic                                         i_stationary,
    input  ewma_ivt_pkg::t_dp_cmd                        i_cmd,
    output ewma_ivt_pkg::t_dp_sts                        o_sts,
    output logic                                         o_accepted,
    output logic                                         o_ready_res,
    output logic [ewma_ivt_pkg::COUNT_W-1:0]             o_samples_counted,
    output logic [ewma_ivt_pkg::VAR_W-1:0]               o_var [ewma_ivt_pkg::AXES]
);

    localparam int AX  = ewma_ivt_pkg::AXES;
    localparam int SW  = ewma_ivt_pkg::SAMPLE_W;
    localparam int MW  = ewma_ivt_pkg::MEAN_W;
    localparam int VW  = ewma_ivt_pkg::VAR_W;
    localparam int AW  = ewma_ivt_pkg::ALPHA_W;
    localparam int CW  = ewma_ivt_pkg::COUNT_W;
    localparam int MAW = ewma_ivt_pkg::MUL_A_W;
    localparam int MBW = ewma_ivt_pkg::MUL_B_W;
    localparam int PW  = ewma_ivt_pkg::PROD_W;

    // Configuration registers.
    logic [AW-1:0]        r_alpha;
    logic [CW-1:0]        r_warm;
    logic [VW-1:0]        r_floor;

    // Statistics.
    logic [CW-1:0]        r_count;
    logic signed [MW-1:0] r_mean [AX];
    logic [VW-1:0]        r_var  [AX];

    // Working registers.
    logic signed [SW-1:0] r_x [AX];
    logic                 r_accepted;
    logic [MW:0]          r_mag;
    logic [VW-1:0]        r_sq;
    logic signed [PW-1:0] r_acc;

    // Result registers.
    logic                 r_o_accepted;
    logic                 r_o_ready;
    logic [CW-1:0]        r_o_count;
    logic [VW-1:0]        r_o_var [AX];

    logic [AW-1:0]        alpha_c;
    logic [AW-1:0]        beta_c;
    logic [CW-1:0]        warm_c;
    logic [CW-1:0]        count_inc;
    logic                 sample_ok;
    logic                 first;
    logic signed [SW-1:0] x_cur;
    logic signed [MW-1:0] mean_cur;
    logic [VW-1:0]        var_cur;
    logic signed [MW+1:0] diff;
    logic [MW+1:0]        diff_abs;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [PW-1:0] acc_full;
    logic signed [PW-1:0] acc_sh;

    // Effective alpha, beta and warm-up count.
    assign alpha_c   = (r_alpha > ewma_ivt_pkg::ONE_Q16) ? ewma_ivt_pkg::ONE_Q16 : r_alpha;
    assign beta_c    = ewma_ivt_pkg::ONE_Q16 - alpha_c;
    assign warm_c    = (r_warm < ewma_ivt_pkg::WARM_MIN) ? ewma_ivt_pkg::WARM_MIN : r_warm;
    assign count_inc = (r_count < warm_c) ? r_count + 1'b1 : r_count;
    assign sample_ok = i_sample_valid && i_stationary;
    assign first     = (count_inc == CW'(1));

    assign o_sts.need_run = !i_func && sample_ok && !first;

    // Operands of the axis under work.
    assign x_cur    = r_x[i_cmd.axis];
    assign mean_cur = r_mean[i_cmd.axis];
    assign var_cur  = r_var[i_cmd.axis];

    // Sample in Q16.16 minus old mean, and its magnitude.
    assign diff     = {{2{x_cur[SW-1]}}, x_cur, 16'h0000} - {{2{mean_cur[MW-1]}}, mean_cur};
    assign diff_abs = diff[MW+1] ? -diff : diff;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            ewma_ivt_pkg::ST_SQH: begin
                mul_a = {1'b0, r_mag};
                mul_b = {1'b0, r_mag[MW:16]};
            end
            ewma_ivt_pkg::ST_SQL: begin
                mul_a = {1'b0, r_mag};
                mul_b = {2'b00, r_mag[15:0]};
            end
            ewma_ivt_pkg::ST_TAH: begin
                mul_a = {2'b00, r_sq[VW-1:16]};
                mul_b = {1'b0, alpha_c};
            end
            ewma_ivt_pkg::ST_TAL: begin
                mul_a = {18'h00000, r_sq[15:0]};
                mul_b = {1'b0, alpha_c};
            end
            ewma_ivt_pkg::ST_TBH: begin
                mul_a = {2'b00, var_cur[VW-1:16]};
                mul_b = {1'b0, beta_c};
            end
            ewma_ivt_pkg::ST_TBL: begin
                mul_a = {18'h00000, var_cur[15:0]};
                mul_b = {1'b0, beta_c};
            end
            ewma_ivt_pkg::ST_MA: begin
                mul_a = {{(MAW-SW){x_cur[SW-1]}}, x_cur};
                mul_b = {1'b0, alpha_c};
            end
            ewma_ivt_pkg::ST_MB: begin
                mul_a = {{(MAW-MW){mean_cur[MW-1]}}, mean_cur};
                mul_b = {1'b0, beta_c};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product, its floor in Q16, and the two accumulator sums.
    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign prod_sh  = prod >>> 16;
    assign acc_full = r_acc + prod;
    assign acc_sh   = r_acc + prod_sh;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ewma_ivt_pkg::ALPHA_RESET;
            r_warm  <= ewma_ivt_pkg::WARM_RESET;
            r_floor <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ewma_ivt_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[AW-1:0];
                ewma_ivt_pkg::CFG_WARM:  r_warm  <= i_cfg_data[CW-1:0];
                ewma_ivt_pkg::CFG_FLOOR: r_floor <= i_cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // Statistics: clear, count, first-sample load and the per-axis sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < AX; i++) begin
                r_mean[i] <= '0;
                r_var[i]  <= '0;
            end
        end else if (i_cmd.accept) begin
            if (i_func) begin
                r_count <= '0;
                for (int i = 0; i < AX; i++) begin
                    r_mean[i] <= '0;
                    r_var[i]  <= '0;
                end
            end else if (sample_ok) begin
                r_count <= count_inc;
                if (first) begin
                    for (int i = 0; i < AX; i++) begin
                        r_mean[i] <= {i_x[i], 16'h0000};
                    end
                end
            end
        end else if (i_cmd.run) begin
            if (i_cmd.step == ewma_ivt_pkg::ST_TBL) begin
                r_var[i_cmd.axis] <= acc_sh[VW-1:0];
            end
            if (i_cmd.step == ewma_ivt_pkg::ST_MB) begin
                r_mean[i_cmd.axis] <= acc_sh[MW-1:0];
            end
        end
    end

    // Sample capture and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_accepted <= !i_func && sample_ok;
            for (int i = 0; i < AX; i++) begin
                r_x[i] <= i_x[i];
            end
        end
        if (i_cmd.run) begin
            case (i_cmd.step)
                ewma_ivt_pkg::ST_MAG: r_mag <= diff_abs[MW:0];
                ewma_ivt_pkg::ST_SQH: r_acc <= prod;
                ewma_ivt_pkg::ST_SQL: r_sq  <= acc_sh[VW-1:0];
                ewma_ivt_pkg::ST_TAH: r_acc <= prod;
                ewma_ivt_pkg::ST_TAL: r_acc <= acc_sh;
                ewma_ivt_pkg::ST_TBH: r_acc <= acc_full;
                ewma_ivt_pkg::ST_MA:  r_acc <= prod;
                default: ;
            endcase
        end
    end

    // Result register, variances floored.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_accepted <= r_accepted;
            r_o_ready    <= (r_count >= warm_c);
            r_o_count    <= r_count;
            for (int i = 0; i < AX; i++) begin
                r_o_var[i] <= (r_var[i] > r_floor) ? r_var[i] : r_floor;
            end
        end
    end

    assign o_accepted        = r_o_accepted;
    assign o_ready_res       = r_o_ready;
    assign o_samples_counted = r_o_count;
    assign o_var             = r_o_var;

endmodule

@@ hw/rtl/ewma_imu_variance_tracker.sv @@
// channel | handshake                 | payload
// --------+---------------------------+-----------------------------------------------------
// input   | i_in_valid / o_in_stall   | i_func, six samples, i_sample_valid, i_stationary
// output  | o_out_valid / i_out_stall | o_accepted, o_ready_res, o_samples_counted, variances
// config  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// An updating transaction is accepted, then runs nine steps per axis for six axes
// (eight of them on the shared 34 x 18 multiplier), and then loads the result.
// A clear, a dropped sample or the first sample after reset or a clear runs no steps.
// Reset is synchronous; no clearing pass follows it.
// A new transaction is taken while a result waits; the next result waits while the
// output is stalled, and the input stays stalled until that result is loaded.
module ewma_imu_variance_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic        i_sample_valid,
    input  logic        i_stationary,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic        o_ready_res,
    output logic [15:0] o_samples_counted,
    output logic [47:0] o_accel_var_x,
    output logic [47:0] o_accel_var_y,
    output logic [47:0] o_accel_var_z,
    output logic [47:0] o_gyro_var_x,
    output logic [47:0] o_gyro_var_y,
    output logic [47:0] o_gyro_var_z
);

    ewma_ivt_pkg::t_dp_cmd cmd;
    ewma_ivt_pkg::t_dp_sts sts;
    logic signed [ewma_ivt_pkg::SAMPLE_W-1:0] x_in [ewma_ivt_pkg::AXES];
    logic [ewma_ivt_pkg::VAR_W-1:0]           var_out [ewma_ivt_pkg::AXES];

    // Axis order: accel x, y, z then gyro x, y, z.
    assign x_in[0] = i_accel_x;
    assign x_in[1] = i_accel_y;
    assign x_in[2] = i_accel_z;
    assign x_in[3] = i_gyro_x;
    assign x_in[4] = i_gyro_y;
    assign x_in[5] = i_gyro_z;

    assign o_accel_var_x = var_out[0];
    assign o_accel_var_y = var_out[1];
    assign o_accel_var_z = var_out[2];
    assign o_gyro_var_x  = var_out[3];
    assign o_gyro_var_y  = var_out[4];
    assign o_gyro_var_z  = var_out[5];

    ewma_ivt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ewma_ivt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_x               (x_in),
        .i_sample_valid    (i_sample_valid),
        .i_stationary      (i_stationary),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_accepted        (o_accepted),
        .o_ready_res       (o_ready_res),
        .o_samples_counted (o_samples_counted),
        .o_var             (var_out)
    );

endmodule

@@ hw/rtl/ewma_ivt_chk.sv @@
`include "ewma_imu_variance_tracker_defines.svh"

module ewma_ivt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_accepted,
    input logic        o_ready_res,
    input logic [15:0] o_samples_counted
);

    // A stalled result stays offered.
    `EVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its count.
    `EVT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_samples_counted))

    // The block works on one transaction at a time.
    `EVT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Ready needs at least the minimum warm-up of two samples.
    `EVT_ASSERT_IMPLY(a_ready_count, i_clk, i_rst_n, o_out_valid && o_ready_res, o_samples_counted >= 16'd2)

    // An accepted sample is always counted.
    `EVT_ASSERT_IMPLY(a_accept_count, i_clk, i_rst_n, o_out_valid && o_accepted, o_samples_counted != 16'd0)

endmodule

bind ewma_imu_variance_tracker ewma_ivt_chk u_chk (.*);

@@ tb/sv/tb_ewma_imu_variance_tracker.sv @@
`timescale 1ns / 100ps

module tb_ewma_imu_variance_tracker;

    typedef struct {
        logic        accepted;
        logic        ready_res;
        logic [15:0] count;
        logic [47:0] var_q [ewma_ivt_pkg::AXES];
    } t_stats;

    // Tracks expected statistics and compares every result transaction in order.
    class variance_scoreboard;
        logic [16:0] alpha_reg;
        logic [15:0] warm_reg;
        logic [47:0] floor_reg;
        logic [15:0] n_counted;
        logic signed [31:0] mean_q [ewma_ivt_pkg::AXES];
        logic [47:0] var_acc [ewma_ivt_pkg::AXES];
        t_stats pending_q[$];
        int errors;

        function new();
            alpha_reg = ewma_ivt_pkg::ALPHA_RESET;
            warm_reg = ewma_ivt_pkg::WARM_RESET;
            floor_reg = '0;
            errors = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            n_counted = '0;
            for (int i = 0; i < ewma_ivt_pkg::AXES; i++) begin
                mean_q[i] = '0;
                var_acc[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [47:0] val);
            if (idx == ewma_ivt_pkg::CFG_ALPHA) alpha_reg = val[16:0];
            else if (idx == ewma_ivt_pkg::CFG_WARM) warm_reg = val[15:0];
            else if (idx == ewma_ivt_pkg::CFG_FLOOR) floor_reg = val;
        endfunction

        // Apply one accepted input transaction and queue its expected result.
        function void note_input(logic fn, logic signed [15:0] smp [ewma_ivt_pkg::AXES],
                                 logic sv, logic st);
            logic [63:0] alpha, beta, warm, mag, sq, v;
            logic signed [63:0] x, m, diff, bm;
            t_stats e;
            alpha = (alpha_reg > ewma_ivt_pkg::ONE_Q16) ? 64'(ewma_ivt_pkg::ONE_Q16)
                                                        : 64'(alpha_reg);
            beta = 64'd65536 - alpha;
            warm = (warm_reg < ewma_ivt_pkg::WARM_MIN) ? 64'(ewma_ivt_pkg::WARM_MIN)
                                                       : 64'(warm_reg);
            e.accepted = 1'b0;
            if (fn) begin
                clear_stats();
            end else if (sv && st) begin
                e.accepted = 1'b1;
                if (64'(n_counted) < warm) n_counted++;
                for (int i = 0; i < ewma_ivt_pkg::AXES; i++) begin
                    x = smp[i];
                    if (n_counted == 16'd1) begin
                        mean_q[i] = 32'(x * 65536);
                    end else begin
                        m = mean_q[i];
                        diff = x * 65536 - m;
                        mag = diff < 0 ? 64'(-diff) : 64'(diff);
                        sq = (mag * mag) >> 16;
                        v = (sq >> 16) * alpha + (((sq & 64'hFFFF) * alpha) >> 16)
                          + (64'(var_acc[i]) >> 16) * beta
                          + (((64'(var_acc[i]) & 64'hFFFF) * beta) >> 16);
                        var_acc[i] = v[47:0];
                        bm = $signed(beta) * m;
                        mean_q[i] = 32'(x * $signed(alpha) + (bm >>> 16));
                    end
                end
            end
            e.ready_res = 64'(n_counted) >= warm;
            e.count = n_counted;
            for (int i = 0; i < ewma_ivt_pkg::AXES; i++)
                e.var_q[i] = (var_acc[i] > floor_reg) ? var_acc[i] : floor_reg;
            pending_q.push_back(e);
        endfunction

        function void check_result(t_stats got);
            t_stats e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.accepted !== e.accepted) begin
                $display("%0t: accepted exp %0d got %0d", $time, e.accepted, got.accepted);
                errors++;
            end
            if (got.ready_res !== e.ready_res) begin
                $display("%0t: ready exp %0d got %0d", $time, e.ready_res, got.ready_res);
                errors++;
            end
            if (got.count !== e.count) begin
                $display("%0t: count exp %0d got %0d", $time, e.count, got.count);
                errors++;
            end
            for (int i = 0; i < ewma_ivt_pkg::AXES; i++)
                if (got.var_q[i] !== e.var_q[i]) begin
                    $display("%0t: variance[%0d] exp %h got %h", $time, i,
                             e.var_q[i], got.var_q[i]);
                    errors++;
                end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_func = 1'b0;
    logic signed [15:0] smp_drv [ewma_ivt_pkg::AXES];
    logic i_sample_valid = 1'b0;
    logic i_stationary = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_accepted, o_ready_res;
    logic [15:0] o_samples_counted;
    logic [47:0] var_out [ewma_ivt_pkg::AXES];

    variance_scoreboard board;
    int long_hold = 0;
    bit stimulus_done = 1'b0;

    always #2 i_clk = ~i_clk;

    ewma_imu_variance_tracker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_func(i_func),
        .i_accel_x(smp_drv[0]), .i_accel_y(smp_drv[1]), .i_accel_z(smp_drv[2]),
        .i_gyro_x(smp_drv[3]), .i_gyro_y(smp_drv[4]), .i_gyro_z(smp_drv[5]),
        .i_sample_valid(i_sample_valid), .i_stationary(i_stationary),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_accepted(o_accepted), .o_ready_res(o_ready_res),
        .o_samples_counted(o_samples_counted),
        .o_accel_var_x(var_out[0]), .o_accel_var_y(var_out[1]), .o_accel_var_z(var_out[2]),
        .o_gyro_var_x(var_out[3]), .o_gyro_var_y(var_out[4]), .o_gyro_var_z(var_out[5])
    );

    initial begin
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) smp_drv[i] = '0;
    end

    // Sample result transactions at the rising edge.
    always @(posedge i_clk) begin
        t_stats got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.accepted = o_accepted;
            got.ready_res = o_ready_res;
            got.count = o_samples_counted;
            for (int i = 0; i < ewma_ivt_pkg::AXES; i++) got.var_q[i] = var_out[i];
            board.check_result(got);
        end
    end

    // Receiver stall pattern, with an occasional long hold-off.
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            i_out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end else if (stimulus_done) begin
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: i_out_stall <= ($urandom_range(0, 1) == 1);
                1: i_out_stall <= ($urandom_range(0, 9) == 0);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one transaction and hold it until accepted; valid stays high after.
    task automatic send_item(logic fn, logic signed [15:0] s [ewma_ivt_pkg::AXES],
                             logic sv, logic st);
        i_in_valid <= 1'b1;
        i_func <= fn;
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) smp_drv[i] <= s[i];
        i_sample_valid <= sv;
        i_stationary <= st;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(fn, s, sv, st);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample(int mode);
        case (mode)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 200)) - 16'sd100;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int count, bit with_pressure);
        logic signed [15:0] s [ewma_ivt_pkg::AXES];
        int burst, mode;
        logic fn, sv, st;
        int r;
        for (int n = 0; n < count; n++) begin
            if (with_pressure && n == count / 2) long_hold = 400;
            if (n == count / 3) drain();
            mode = $urandom_range(0, 3);
            for (int i = 0; i < ewma_ivt_pkg::AXES; i++)
                s[i] = ($urandom_range(0, 15) == 0) ? pick_sample($urandom_range(0, 1))
                                                    : pick_sample(mode < 2 ? 2 : 3);
            r = $urandom_range(0, 99);
            fn = (r < 3);
            sv = (r < 92) || ($urandom_range(0, 1) == 1);
            st = (r < 88) || ($urandom_range(0, 1) == 1);
            send_item(fn, s, sv, st);
            burst = $urandom_range(0, 7);
            if (burst == 0) begin
                go_idle();
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        logic signed [15:0] s [ewma_ivt_pkg::AXES];
        board = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: first sample, extremes, drops, clear, saturated alpha.
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'd3);
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) s[i] = (i % 2) ? 16'sh7FFF : 16'sh8000;
        send_item(1'b0, s, 1'b1, 1'b1);
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) s[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
        send_item(1'b0, s, 1'b1, 1'b1);
        send_item(1'b0, s, 1'b0, 1'b1);
        send_item(1'b0, s, 1'b1, 1'b0);
        send_item(1'b0, s, 1'b1, 1'b1);
        send_item(1'b0, s, 1'b1, 1'b1);
        send_item(1'b1, s, 1'b1, 1'b1);
        send_item(1'b0, s, 1'b1, 1'b1);
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) s[i] = 16'sh0000;
        send_item(1'b0, s, 1'b1, 1'b1);
        drain();
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'h1FFFF);
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'd0);
        write_cfg(ewma_ivt_pkg::CFG_FLOOR, 48'h123456789);
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) s[i] = 16'sh7FFF;
        send_item(1'b0, s, 1'b1, 1'b1);
        send_item(1'b0, s, 1'b1, 1'b1);
        for (int i = 0; i < ewma_ivt_pkg::AXES; i++) s[i] = -16'sd1;
        send_item(1'b0, s, 1'b1, 1'b1);
        drain();
        // Warm-up lowered below the current count.
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'd1);
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'd0);
        send_item(1'b0, s, 1'b1, 1'b1);
        drain();

        // Random phases over several register settings.
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'd655);
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'd100);
        write_cfg(ewma_ivt_pkg::CFG_FLOOR, 48'd0);
        random_phase(300, 1'b1);
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'd65536);
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'hFFFF);
        write_cfg(ewma_ivt_pkg::CFG_FLOOR, 48'hFFFFFFFFFFFF);
        random_phase(150, 1'b0);
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'($urandom_range(1, 65535)));
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'($urandom_range(2, 40)));
        write_cfg(ewma_ivt_pkg::CFG_FLOOR, 48'($urandom_range(0, 32'hFFFFFF)));
        random_phase(300, 1'b1);
        write_cfg(ewma_ivt_pkg::CFG_ALPHA, 48'd20000);
        write_cfg(ewma_ivt_pkg::CFG_WARM, 48'd2);
        write_cfg(ewma_ivt_pkg::CFG_FLOOR, 48'd0);
        random_phase(250, 1'b0);

        stimulus_done = 1'b1;
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
